@@ rtl/ali_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the array list block
// no dependencies

package ali_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 5;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_INS,
    S_DEL,
    S_DONE
  } state_t;

endpackage

@@ rtl/array_list_insert_delete.sv @@
`timescale 1ns / 1ps
// ordered list with insert, delete and read at a position
// read returns the addressed entry; delete also moves the later entries down one place
// insert moves entries from the tail up one place, none when appending; one entry moved per cycle
// one word in flight at a time; the ram's single write port sets the shift rate
// reset (rst, synchronous) empties the list and clears out_valid; no clearing pass
// depends on ali_pkg and ali_ram

module array_list_insert_delete #(
  parameter int DEPTH = ali_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ali_pkg::OP_W-1:0]         op,
  input  logic [ali_pkg::POS_W-1:0]        position,
  input  logic signed [ali_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ali_pkg::STATUS_W-1:0]     status,
  output logic signed [ali_pkg::DATA_W-1:0] result_value,
  output logic [ali_pkg::COUNT_OUT_W-1:0]  entry_count
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > ali_pkg::POS_W) ? CNT_W : ali_pkg::POS_W;

  ali_pkg::state_t  state, state_next;
  ali_pkg::status_t res_status, res_status_next;
  logic [ali_pkg::DATA_W-1:0] res_value, res_value_next;
  logic [ali_pkg::DATA_W-1:0] val_q, val_q_next;
  logic [CW-1:0]    pos_q, pos_q_next;
  logic [CW-1:0]    idx, idx_next;
  logic             is_del, is_del_next;
  logic             wr_pend, wr_pend_next;
  logic [AW-1:0]    wr_addr, wr_addr_next;
  logic [CNT_W-1:0] count, count_next;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ali_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [ali_pkg::DATA_W-1:0] ram_rdata;

  logic [CW-1:0] pos_in;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic          out_load;

  assign pos_in   = CW'(position);
  assign cnt_ext  = CW'(count);
  assign idx_dec  = idx - CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign in_stall = (state != ali_pkg::S_IDLE);

  ali_ram #(
    .WIDTH (ali_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_value_next  = res_value;
    val_q_next      = val_q;
    pos_q_next      = pos_q;
    idx_next        = idx;
    is_del_next     = is_del;
    wr_pend_next    = wr_pend;
    wr_addr_next    = wr_addr;
    count_next      = count;
    ram_we          = 1'b0;
    ram_waddr       = wr_addr;
    ram_wdata       = ram_rdata;
    ram_raddr       = idx[AW-1:0];
    out_load        = 1'b0;

    case (state)
      ali_pkg::S_IDLE: begin
        // fetch the addressed entry right away for read and delete
        ram_raddr = pos_in[AW-1:0];
        if (in_valid) begin
          pos_q_next     = pos_in;
          val_q_next     = value;
          res_value_next = '0;
          wr_pend_next   = 1'b0;
          case (ali_pkg::op_t'(op))
            ali_pkg::OP_INSERT: begin
              if (pos_in > cnt_ext) begin
                res_status_next = ali_pkg::ST_BADPOS;
                state_next      = ali_pkg::S_DONE;
              end else if (count >= CNT_W'(DEPTH)) begin
                res_status_next = ali_pkg::ST_FULL;
                state_next      = ali_pkg::S_DONE;
              end else begin
                idx_next   = cnt_ext;
                state_next = ali_pkg::S_INS;
              end
            end
            ali_pkg::OP_DELETE, ali_pkg::OP_READ: begin
              if (pos_in < cnt_ext) begin
                is_del_next = (ali_pkg::op_t'(op) == ali_pkg::OP_DELETE);
                state_next  = ali_pkg::S_FETCH;
              end else begin
                res_status_next = ali_pkg::ST_BADPOS;
                state_next      = ali_pkg::S_DONE;
              end
            end
            default: begin
              res_status_next = ali_pkg::ST_BADPOS;
              state_next      = ali_pkg::S_DONE;
            end
          endcase
        end
      end

      ali_pkg::S_FETCH: begin
        res_value_next  = ram_rdata;
        res_status_next = ali_pkg::ST_OK;
        if (is_del) begin
          idx_next   = pos_q;
          state_next = ali_pkg::S_DEL;
        end else begin
          state_next = ali_pkg::S_DONE;
        end
      end

      ali_pkg::S_INS: begin
        // move entries up from the tail, one read and one write per cycle
        if (wr_pend) begin
          ram_we = 1'b1;
        end
        if (idx != pos_q) begin
          ram_raddr    = idx_dec[AW-1:0];
          wr_pend_next = 1'b1;
          wr_addr_next = idx[AW-1:0];
          idx_next     = idx_dec;
        end else if (wr_pend) begin
          wr_pend_next = 1'b0;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = pos_q[AW-1:0];
          ram_wdata       = val_q;
          count_next      = count + CNT_W'(1);
          res_status_next = ali_pkg::ST_OK;
          state_next      = ali_pkg::S_DONE;
        end
      end

      ali_pkg::S_DEL: begin
        // move entries down toward the gap, last write lands as we leave
        if (wr_pend) begin
          ram_we = 1'b1;
        end
        if (idx_inc < cnt_ext) begin
          ram_raddr    = idx_inc[AW-1:0];
          wr_pend_next = 1'b1;
          wr_addr_next = idx[AW-1:0];
          idx_next     = idx_inc;
        end else begin
          wr_pend_next = 1'b0;
          count_next   = count - CNT_W'(1);
          state_next   = ali_pkg::S_DONE;
        end
      end

      ali_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ali_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ali_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ali_pkg::S_IDLE;
      count     <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      wr_pend <= wr_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_value  <= res_value_next;
    val_q      <= val_q_next;
    pos_q      <= pos_q_next;
    idx        <= idx_next;
    is_del     <= is_del_next;
    wr_addr    <= wr_addr_next;
    if (out_load) begin
      status       <= res_status;
      result_value <= res_value;
      entry_count  <= ali_pkg::COUNT_OUT_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) < CW'(DEPTH)))
    else $error("ram write outside the list");

  a_write_only_shifting: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ali_pkg::S_INS || state == ali_pkg::S_DEL))
    else $error("ram write outside insert or delete");

  a_count_changes_at_done: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == ali_pkg::S_DONE))
    else $error("entry count changed without a finished word");

  a_ins_pending_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ali_pkg::S_INS && wr_pend) |-> (CW'(wr_addr) == idx_inc))
    else $error("insert shift writes to the wrong entry");
`endif

endmodule

@@ rtl/ali_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module ali_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
